[hw/rtl/cba_pkg.sv]
`timescale 1ns / 1ps

package cba_pkg;

	// Default depth of the line store, in pixels per row.
	localparam int DEFAULT_MAX_WIDTH = 2048;

	// Register indexes on the configuration port and their reset values.
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
	localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;

	// What an accepted item produces once it reaches the combine stage.
	localparam logic [2:0] KIND_NONE  = 3'd0; // no block finishes on this pixel
	localparam logic [2:0] KIND_PASS  = 3'd1; // 1x1 block, chroma kept
	localparam logic [2:0] KIND_HPAIR = 3'd2; // 2 columns, 1 row
	localparam logic [2:0] KIND_VPAIR = 3'd3; // 1 column, 2 rows
	localparam logic [2:0] KIND_FULL  = 3'd4; // full 2x2 block

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] r;
		logic [7:0] b;
	} cba_pixel_t;

	// Control that travels with an item from the counters to the combine stage.
	typedef struct packed {
		logic [2:0] kind;
		logic       frame_end;
	} cba_item_t;

endpackage

[hw/rtl/cba_ctrl.sv]
`timescale 1ns / 1ps

module cba_ctrl #(
	parameter int MAX_WIDTH = cba_pkg::DEFAULT_MAX_WIDTH,
	parameter int CW = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                accept,
	input  cba_pkg::cba_pixel_t pix,
	output cba_pkg::cba_pixel_t left,
	output cba_pkg::cba_item_t  item,
	output logic                store_wr,
	output logic [CW-2:0]       store_addr,
	output cba_pkg::cba_pixel_t store_even
);
	import cba_pkg::*;

	localparam int EW = (CW + 1 > 12) ? CW + 1 : 12;

	logic [11:0]   frame_width_q;
	logic [15:0]   frame_height_q;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	cba_pixel_t    left_q;

	logic [EW-1:0] width_ext;
	logic [EW-1:0] width_eff;
	logic [15:0]   height_eff;
	logic          narrow;
	logic          last_col;
	logic          last_row;
	logic          col_odd;
	logic          row_odd;

	// Effective frame size: zero counts as one, width saturates at MAX_WIDTH.
	always_comb begin
		width_ext = EW'(frame_width_q);
		if (frame_width_q == 12'd0) begin
			width_eff = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			width_eff = EW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		height_eff = (frame_height_q == 16'd0) ? 16'd1 : frame_height_q;
	end

	assign narrow   = (width_eff < EW'(2)) || (height_eff < 16'd2);
	assign last_col = (EW'(col_q) + EW'(1)) >= width_eff;
	assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, height_eff};
	assign col_odd  = col_q[0];
	assign row_odd  = row_q[0];

	// Decide what the pixel at the current position finishes.
	always_comb begin
		item.kind      = KIND_NONE;
		item.frame_end = last_col && last_row;
		store_wr       = 1'b0;
		if (narrow) begin
			item.kind = KIND_PASS;
		end else if (!row_odd) begin
			if (last_row) begin
				if (col_odd) begin
					item.kind = KIND_HPAIR;
				end else if (last_col) begin
					item.kind = KIND_PASS;
				end
			end else begin
				store_wr = accept && (col_odd || last_col);
			end
		end else begin
			if (col_odd) begin
				item.kind = KIND_FULL;
			end else if (last_col) begin
				item.kind = KIND_VPAIR;
			end
		end
	end

	// The even half of a stored pair is the previous pixel, or this one when
	// an odd last column leaves it alone.
	assign store_even = col_odd ? left_q : pix;
	assign store_addr = col_q[CW-1:1];
	assign left       = left_q;

	// Configuration registers, position counters and the previous pixel; a write to a known register restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
			left_q         <= '0;
		end else begin
			if (cfg_write && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
				if (cfg_index == CFG_FRAME_WIDTH) begin
					frame_width_q <= cfg_data[11:0];
				end else begin
					frame_height_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			// The previous pixel is the left half of any pair finished now.
			if (accept) begin
				left_q <= pix;
			end
		end
	end

endmodule

[hw/rtl/cba_line_store.sv]
`timescale 1ns / 1ps

module cba_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic                clk,
	input  logic                accept,
	input  logic                wr,
	input  logic [AW-1:0]       addr,
	input  cba_pkg::cba_pixel_t even_pix,
	input  cba_pkg::cba_pixel_t odd_pix,
	output cba_pkg::cba_pixel_t rd_even,
	output cba_pkg::cba_pixel_t rd_odd
);
	import cba_pkg::*;

	// One word holds a column pair of the last even row: even pixel on top.
	logic [47:0] mem [DEPTH];
	logic [47:0] rd_q;

	// Reads follow each accepted item and then hold while the pipeline waits.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[addr] <= {even_pix, odd_pix};
		end
		if (accept) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_even = rd_q[47:24];
	assign rd_odd  = rd_q[23:0];

endmodule

[hw/rtl/cba_combine.sv]
`timescale 1ns / 1ps

module cba_combine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cba_pkg::cba_pixel_t pix,
	input  cba_pkg::cba_pixel_t left,
	input  cba_pkg::cba_item_t  item,
	input  cba_pkg::cba_pixel_t rd_even,
	input  cba_pkg::cba_pixel_t rd_odd,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          luma_top_left,
	output logic [7:0]          luma_top_right,
	output logic [7:0]          luma_bottom_left,
	output logic [7:0]          luma_bottom_right,
	output logic [7:0]          block_red,
	output logic [7:0]          block_blue,
	output logic [1:0]          block_columns,
	output logic [1:0]          block_rows,
	output logic                frame_end
);
	import cba_pkg::*;

	logic       valid_s1;
	cba_item_t  item_s1;
	cba_pixel_t pix_s1;
	cba_pixel_t left_s1;
	logic       out_valid_q;
	logic       move_s1;
	logic       accept;

	logic [7:0] tl, tr, bl, br, red, blue;
	logic [1:0] cols, rows;
	logic [9:0] sum_r, sum_b;

	// The stage moves when the output register is empty or being emptied.
	assign move_s1  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !move_s1;
	assign accept   = in_valid && !in_stall;

	// Place the luma samples and average the chroma samples present in the block.
	always_comb begin
		tl    = 8'd0;
		tr    = 8'd0;
		bl    = 8'd0;
		br    = 8'd0;
		cols  = 2'd1;
		rows  = 2'd1;
		sum_r = 10'd0;
		sum_b = 10'd0;
		red   = pix_s1.r;
		blue  = pix_s1.b;
		case (item_s1.kind)
			KIND_HPAIR: begin
				tl    = left_s1.y;
				tr    = pix_s1.y;
				cols  = 2'd2;
				sum_r = 10'(left_s1.r) + 10'(pix_s1.r);
				sum_b = 10'(left_s1.b) + 10'(pix_s1.b);
				red   = sum_r[8:1];
				blue  = sum_b[8:1];
			end
			KIND_VPAIR: begin
				tl    = rd_even.y;
				bl    = pix_s1.y;
				rows  = 2'd2;
				sum_r = 10'(rd_even.r) + 10'(pix_s1.r);
				sum_b = 10'(rd_even.b) + 10'(pix_s1.b);
				red   = sum_r[8:1];
				blue  = sum_b[8:1];
			end
			KIND_FULL: begin
				tl    = rd_even.y;
				tr    = rd_odd.y;
				bl    = left_s1.y;
				br    = pix_s1.y;
				cols  = 2'd2;
				rows  = 2'd2;
				sum_r = 10'(rd_even.r) + 10'(rd_odd.r) + 10'(left_s1.r) + 10'(pix_s1.r);
				sum_b = 10'(rd_even.b) + 10'(rd_odd.b) + 10'(left_s1.b) + 10'(pix_s1.b);
				red   = sum_r[9:2];
				blue  = sum_b[9:2];
			end
			default: begin
				tl = pix_s1.y;
			end
		endcase
	end

	// Stage 1 control and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid_q <= (item_s1.kind != KIND_NONE);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of stage 1 and of the output.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			pix_s1  <= pix;
			left_s1 <= left;
		end
		if (move_s1) begin
			luma_top_left     <= tl;
			luma_top_right    <= tr;
			luma_bottom_left  <= bl;
			luma_bottom_right <= br;
			block_red         <= red;
			block_blue        <= blue;
			block_columns     <= cols;
			block_rows        <= rows;
			frame_end         <= item_s1.frame_end;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/chroma_block_averager.sv]
`timescale 1ns / 1ps

// 4:2:0 chroma averager over 2x2 blocks of a raster-order YCrCb stream.
// Input channel: in_valid / in_stall with luma, chroma_red, chroma_blue; one
// pixel is taken at each edge where in_valid is high and in_stall low.
// Output channel: out_valid / out_stall; one block item leaves at each edge
// where out_valid is high and out_stall low. A block appears when its last
// pixel arrives; pixels that finish no block produce nothing.
// A block is registered in stage 1 when its last pixel is taken and then in
// the output register, where it is shown; a receiver stall can hold it.
// Throughput: one pixel per cycle while in_stall is low; the line store takes
// one column-pair word per port access, so reads and writes never compete.
// When the receiver stalls, the output register holds and one more item
// waits in the stage before it; after that in_stall rises.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
// frame_width (0) or frame_height (1); such a write restarts the frame.
// Reset clears the counters and loads 640 x 480; the line store is not
// cleared and needs no clearing pass, since every odd row reads only what
// the even row above it wrote.

module chroma_block_averager #(
	parameter int MAX_WIDTH = cba_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  luma,
	input  logic [7:0]  chroma_red,
	input  logic [7:0]  chroma_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  luma_top_left,
	output logic [7:0]  luma_top_right,
	output logic [7:0]  luma_bottom_left,
	output logic [7:0]  luma_bottom_right,
	output logic [7:0]  block_red,
	output logic [7:0]  block_blue,
	output logic [1:0]  block_columns,
	output logic [1:0]  block_rows,
	output logic        frame_end
);
	import cba_pkg::*;

	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = AW + 1;

	cba_pixel_t    pix;
	cba_pixel_t    left;
	cba_pixel_t    rd_even;
	cba_pixel_t    rd_odd;
	cba_pixel_t    store_even;
	cba_item_t     item;
	logic          accept;
	logic          store_wr;
	logic [AW-1:0] store_addr;

	assign cfg_ready = 1'b1;
	assign pix       = '{y: luma, r: chroma_red, b: chroma_blue};
	assign accept    = in_valid && !in_stall;

	cba_ctrl #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW(CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pix       (pix),
		.left      (left),
		.item      (item),
		.store_wr  (store_wr),
		.store_addr(store_addr),
		.store_even(store_even)
	);

	// An odd last column on an even row stores its pixel in both halves.
	cba_line_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk     (clk),
		.accept  (accept),
		.wr      (store_wr),
		.addr    (store_addr),
		.even_pix(store_even),
		.odd_pix (pix),
		.rd_even (rd_even),
		.rd_odd  (rd_odd)
	);

	cba_combine u_combine (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pix              (pix),
		.left             (left),
		.item             (item),
		.rd_even          (rd_even),
		.rd_odd           (rd_odd),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.luma_top_left    (luma_top_left),
		.luma_top_right   (luma_top_right),
		.luma_bottom_left (luma_bottom_left),
		.luma_bottom_right(luma_bottom_right),
		.block_red        (block_red),
		.block_blue       (block_blue),
		.block_columns    (block_columns),
		.block_rows       (block_rows),
		.frame_end        (frame_end)
	);

endmodule
